[rtl/ttc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

    localparam int OP_W      = 3;
    localparam int PERIOD_W  = 16;
    localparam int BPB_W     = 5;
    localparam int PULSE_W   = 8;
    localparam int RAMP_W    = 8;
    localparam int MS_W      = 32;
    localparam int SPAN_W    = BPB_W + PERIOD_W;
    localparam int TAPS_W    = 8;
    localparam int NUM_W     = MS_W + RAMP_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int DIV_NW = SPAN_W + RAMP_W;
    localparam int DIV_DW = SPAN_W;
    localparam int DIV_CW = $clog2(DIV_NW);

    localparam logic signed [PERIOD_W:0] TAP_GUARD = 17'sd10;
    localparam logic [RAMP_W-1:0]        RAMP_TOP  = 8'hFF;
    localparam logic [TAPS_W-1:0]        TAPS_MAX  = 8'd255;

    localparam logic [BPB_W-1:0]    RST_BPB     = 5'd4;
    localparam logic [PULSE_W-1:0]  RST_PULSE   = 8'd100;
    localparam logic [PERIOD_W-1:0] RST_MIN_P   = 16'd240;
    localparam logic [PERIOD_W-1:0] RST_MAX_P   = 16'd1500;
    localparam logic [PERIOD_W-1:0] RST_TAP_WIN = 16'd2000;
    localparam logic [PERIOD_W-1:0] RST_PERIOD  = 16'd499;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 3'd0,
        OP_TAP  = 3'd1,
        OP_LOCK = 3'd2,
        OP_LOAD = 3'd3,
        OP_EXT  = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPB     = 3'd0,
        CFG_PULSE   = 3'd1,
        CFG_MIN_P   = 3'd2,
        CFG_MAX_P   = 3'd3,
        CFG_TAP_WIN = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP_MUL,
        S_RAMP_CHK,
        S_RAMP_DIV,
        S_TAP_DIV,
        S_MARK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic                beat_out;
        logic                bar_out;
        logic                tapping_led;
        logic [RAMP_W-1:0]   ramp_level;
        logic [PERIOD_W-1:0] beat_period;
        logic [BPB_W-1:0]    beat_index;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/ttc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ttc_in_if import ttc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PERIOD_W-1:0] period_value;

    modport source (output valid, op, period_value, input ready);
    modport sink   (input valid, op, period_value, output ready);
endinterface

interface ttc_out_if import ttc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                beat_out;
    logic                bar_out;
    logic                tapping_led;
    logic [RAMP_W-1:0]   ramp_level;
    logic [PERIOD_W-1:0] beat_period;
    logic [BPB_W-1:0]    beat_index;

    modport source (output valid, beat_out, bar_out, tapping_led, ramp_level,
                    beat_period, beat_index, input ready);
    modport sink   (input valid, beat_out, bar_out, tapping_led, ramp_level,
                    beat_period, beat_index, output ready);
endinterface

interface ttc_cfg_if import ttc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/ttc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttc_div import ttc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_dsr, n_dsr;

    logic [DIV_DW:0]   w_shift;
    logic [DIV_DW+1:0] w_diff;

    assign w_shift = {r_rem, r_quo[DIV_NW-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CW'(DIV_NW - 1);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[DIV_DW+1]) begin
                n_rem = w_diff[DIV_DW-1:0];
                n_quo = {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DIV_DW-1:0];
                n_quo = {r_quo[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

[rtl/tap_tempo_beat_bar_clock_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lock, load and external beat items go idle to finish; a tap outside the window adds mark,
// a tap inside it tap divide and mark; a tick adds the ramp states while a bar ramp runs.
// One item at a time; the 29-step shared bit-serial divider sets the worst case.
// The result sits in an output register, so the next item is taken while it waits.
// Reset (synchronous, active low) restores state and config registers to defaults, period 499 ms, ramp 255.

module tap_tempo_beat_bar_clock_core import ttc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ttc_in_if.sink    i_in,
    ttc_out_if.source o_out,
    ttc_cfg_if.sink   i_cfg
);

    logic [BPB_W-1:0]    r_bpb;
    logic [PULSE_W-1:0]  r_pulse_len;
    logic [PERIOD_W-1:0] r_min_p;
    logic [PERIOD_W-1:0] r_max_p;
    logic [PERIOD_W-1:0] r_tap_win;

    t_state              r_state, n_state;
    logic [MS_W-1:0]     r_ms, n_ms;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [BPB_W-1:0]    r_beat_num, n_beat_num;
    logic [PERIOD_W-1:0] r_wait, n_wait;
    logic [PULSE_W-1:0]  r_beat_left, n_beat_left;
    logic [PULSE_W-1:0]  r_bar_left, n_bar_left;
    logic [PERIOD_W-1:0] r_tap_left, n_tap_left;
    logic [PERIOD_W-1:0] r_tap_start, n_tap_start;
    logic [TAPS_W-1:0]   r_tap_total, n_tap_total;
    logic [MS_W-1:0]     r_ramp_start, n_ramp_start;
    logic [SPAN_W-1:0]   r_ramp_span, n_ramp_span;
    logic                r_audio_en, n_audio_en;
    logic                r_beat_lvl, n_beat_lvl;
    logic                r_bar_lvl, n_bar_lvl;
    logic                r_led_lvl, n_led_lvl;
    logic [RAMP_W-1:0]   r_ramp, n_ramp;
    logic [NUM_W-1:0]    r_num, n_num;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic                w_in_acc;
    logic signed [PERIOD_W:0] w_gap;
    logic                w_guard_ok;
    logic [MS_W-1:0]     w_elapsed;
    logic [PERIOD_W-1:0] w_val_lo;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign w_gap      = $signed({1'b0, r_period}) - $signed({1'b0, r_wait});
    assign w_guard_ok = (w_gap >= TAP_GUARD);
    assign w_elapsed  = r_ms - r_ramp_start;
    assign w_val_lo   = (i_in.period_value < r_min_p) ? r_min_p : i_in.period_value;

    ttc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb       <= RST_BPB;
            r_pulse_len <= RST_PULSE;
            r_min_p     <= RST_MIN_P;
            r_max_p     <= RST_MAX_P;
            r_tap_win   <= RST_TAP_WIN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_BPB:     r_bpb       <= i_cfg.data[BPB_W-1:0];
                CFG_PULSE:   r_pulse_len <= i_cfg.data[PULSE_W-1:0];
                CFG_MIN_P:   r_min_p     <= i_cfg.data;
                CFG_MAX_P:   r_max_p     <= i_cfg.data;
                CFG_TAP_WIN: r_tap_win   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [BPB_W:0]     v_next_beat;
        logic [PULSE_W-1:0] v_bar;
        logic [TAPS_W-1:0]  v_total;

        v_next_beat  = '0;
        v_bar        = '0;
        v_total      = '0;
        n_state      = r_state;
        n_ms         = r_ms;
        n_period     = r_period;
        n_beat_num   = r_beat_num;
        n_wait       = r_wait;
        n_beat_left  = r_beat_left;
        n_bar_left   = r_bar_left;
        n_tap_left   = r_tap_left;
        n_tap_start  = r_tap_start;
        n_tap_total  = r_tap_total;
        n_ramp_start = r_ramp_start;
        n_ramp_span  = r_ramp_span;
        n_audio_en   = r_audio_en;
        n_beat_lvl   = r_beat_lvl;
        n_bar_lvl    = r_bar_lvl;
        n_led_lvl    = r_led_lvl;
        n_ramp       = r_ramp;
        n_num        = r_num;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_out.ready;
        w_div_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_FINISH;
                    case (t_op'(i_in.op))
                        OP_TICK: begin
                            n_ms = r_ms + 1'b1;
                            if (r_beat_left != '0) begin
                                n_beat_left = r_beat_left - 1'b1;
                                n_beat_lvl  = 1'b1;
                            end else begin
                                n_beat_lvl  = 1'b0;
                            end
                            v_bar = r_bar_left;
                            if (r_wait != '0) begin
                                n_wait = r_wait - 1'b1;
                            end else begin
                                v_next_beat = {1'b0, r_beat_num} + 1'b1;
                                if (v_next_beat >= {1'b0, r_bpb}) begin
                                    v_next_beat  = '0;
                                    v_bar        = r_pulse_len;
                                    n_ramp_start = r_ms + 1'b1;
                                    n_ramp_span  = {{PERIOD_W{1'b0}}, r_bpb}
                                                 * {{BPB_W{1'b0}}, r_period};
                                end
                                n_beat_num  = v_next_beat[BPB_W-1:0];
                                n_beat_lvl  = 1'b1;
                                n_beat_left = r_pulse_len;
                                n_wait      = r_period - 1'b1;
                            end
                            if (v_bar != '0) begin
                                n_bar_left = v_bar - 1'b1;
                                n_bar_lvl  = 1'b1;
                            end else begin
                                n_bar_left = v_bar;
                                n_bar_lvl  = 1'b0;
                            end
                            if (r_tap_left != '0) begin
                                n_led_lvl  = 1'b1;
                                n_tap_left = r_tap_left - 1'b1;
                            end else begin
                                n_led_lvl  = 1'b0;
                            end
                            if (n_ramp_span == '0) begin
                                n_ramp = RAMP_TOP;
                            end else begin
                                n_state = S_RAMP_MUL;
                            end
                        end
                        OP_TAP: begin
                            if (r_tap_left != '0) begin
                                v_total     = (r_tap_total < TAPS_MAX) ?
                                              r_tap_total + 1'b1 : r_tap_total;
                                n_tap_total = v_total;
                                w_div_req.start    = 1'b1;
                                w_div_req.dividend = DIV_NW'(r_ms[PERIOD_W-1:0] - r_tap_start);
                                w_div_req.divisor  = DIV_DW'(v_total);
                                n_state = S_TAP_DIV;
                            end else begin
                                n_tap_start = r_ms[PERIOD_W-1:0];
                                n_tap_total = '0;
                                n_beat_num  = r_bpb;
                                n_state     = S_MARK;
                            end
                        end
                        OP_LOCK: begin
                            if (r_tap_left != '0) begin
                                n_tap_left = '0;
                                n_audio_en = 1'b0;
                            end else begin
                                n_audio_en = 1'b1;
                                n_tap_left = r_tap_win;
                            end
                        end
                        OP_LOAD: begin
                            n_period = (w_val_lo > r_max_p) ? r_max_p : w_val_lo;
                        end
                        OP_EXT: begin
                            if (r_audio_en) begin
                                n_tap_left = r_tap_win;
                                if (w_guard_ok) begin
                                    n_wait = '0;
                                end
                                n_period = (i_in.period_value > r_max_p) ?
                                           r_max_p : i_in.period_value;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RAMP_MUL: begin
                n_num   = {w_elapsed, {RAMP_W{1'b0}}} - {{RAMP_W{1'b0}}, w_elapsed};
                n_state = S_RAMP_CHK;
            end
            S_RAMP_CHK: begin
                if (r_num >= NUM_W'({r_ramp_span, {RAMP_W{1'b0}}})) begin
                    n_ramp  = '0;
                    n_state = S_FINISH;
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_num[DIV_NW-1:0];
                    w_div_req.divisor  = r_ramp_span;
                    n_state = S_RAMP_DIV;
                end
            end
            S_RAMP_DIV: begin
                if (w_div_rsp.done) begin
                    n_ramp  = RAMP_TOP - w_div_rsp.quotient[RAMP_W-1:0];
                    n_state = S_FINISH;
                end
            end
            S_TAP_DIV: begin
                if (w_div_rsp.done) begin
                    n_period = w_div_rsp.quotient[PERIOD_W-1:0];
                    n_state  = S_MARK;
                end
            end
            S_MARK: begin
                n_tap_left = r_tap_win;
                if (w_guard_ok) begin
                    n_wait = '0;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid       = 1'b1;
                    n_out.beat_out    = r_beat_lvl;
                    n_out.bar_out     = r_bar_lvl;
                    n_out.tapping_led = r_led_lvl;
                    n_out.ramp_level  = r_ramp;
                    n_out.beat_period = r_period;
                    n_out.beat_index  = r_beat_num;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ms         <= '0;
            r_period     <= RST_PERIOD;
            r_beat_num   <= '0;
            r_wait       <= '0;
            r_beat_left  <= '0;
            r_bar_left   <= '0;
            r_tap_left   <= '0;
            r_tap_start  <= '0;
            r_tap_total  <= '0;
            r_ramp_start <= '0;
            r_ramp_span  <= '0;
            r_audio_en   <= 1'b1;
            r_beat_lvl   <= 1'b0;
            r_bar_lvl    <= 1'b0;
            r_led_lvl    <= 1'b0;
            r_ramp       <= RAMP_TOP;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ms         <= n_ms;
            r_period     <= n_period;
            r_beat_num   <= n_beat_num;
            r_wait       <= n_wait;
            r_beat_left  <= n_beat_left;
            r_bar_left   <= n_bar_left;
            r_tap_left   <= n_tap_left;
            r_tap_start  <= n_tap_start;
            r_tap_total  <= n_tap_total;
            r_ramp_start <= n_ramp_start;
            r_ramp_span  <= n_ramp_span;
            r_audio_en   <= n_audio_en;
            r_beat_lvl   <= n_beat_lvl;
            r_bar_lvl    <= n_bar_lvl;
            r_led_lvl    <= n_led_lvl;
            r_ramp       <= n_ramp;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_out <= n_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.beat_out    = r_out.beat_out;
    assign o_out.bar_out     = r_out.bar_out;
    assign o_out.tapping_led = r_out.tapping_led;
    assign o_out.ramp_level  = r_out.ramp_level;
    assign o_out.beat_period = r_out.beat_period;
    assign o_out.beat_index  = r_out.beat_index;

`ifndef SYNTHESIS
    a_div_busy_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.busy |-> (r_state == S_RAMP_DIV || r_state == S_TAP_DIV))
        else $error("divider busy outside a divide state");

    a_ramp_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAMP_DIV && w_div_rsp.done)
            |-> (w_div_rsp.quotient[DIV_NW-1:RAMP_W] == '0))
        else $error("ramp quotient exceeds ramp range");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && !o_out.ready)) |-> (r_state == S_FINISH))
        else $error("result loaded outside finish state");
`endif

endmodule

`default_nettype wire
